>>> hdl/sph_pkg.sv
// ----------------------------------------------------------------------------
// Shape point hit test package
// Shape kind codes and shared widths.
// ----------------------------------------------------------------------------
`default_nettype none
package sph_pkg;
    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_RECT = 2'd1;
    localparam logic [1:0] CMD_CIRC = 2'd2;
    localparam logic [1:0] CMD_BOX  = 2'd3;
    localparam int CW = 16;
endpackage
`default_nettype wire

>>> hdl/shape_point_hit_test_core.sv
// ----------------------------------------------------------------------------
// Shape point hit test core
// Pipelined hit test of a point against a segment, outline, circle or box.
// ----------------------------------------------------------------------------
// channel  | ports                                  | direction
// input    | s_valid s_ready s_command .. s_tolerance | in
// result   | m_valid m_ready m_hit                    | out
//
// One item enters per cycle unless the output stalls; four stages plus output.
// Stage 1: differences. Stage 2: 17x17 and 18x18 squares and products.
// Stage 3: sums, tolerance subtraction, endpoint and circle compares.
// Stage 4: 34x34 compare split into partial products registered. Stage 5:
// final compare and kind select.
// Reset clears only valid bits. A stall freezes every stage at once.
`default_nettype none
module shape_point_hit_test_core
    import sph_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic signed [15:0] s_shape_ax,
    input  wire logic signed [15:0] s_shape_ay,
    input  wire logic signed [15:0] s_shape_bx,
    input  wire logic signed [15:0] s_shape_by,
    input  wire logic signed [15:0] s_point_x,
    input  wire logic signed [15:0] s_point_y,
    input  wire logic [7:0]  s_tolerance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit
);
    // global advance: whole pipe moves when output is free
    logic adv;
    logic [4:0] v_reg;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], s_valid};
        end
    end
    assign m_valid = v_reg[4];

    // ---------------- stage 1: differences and comparisons ----------------
    logic [1:0] k1_reg;
    logic signed [17:0] w1_reg;
    logic signed [16:0] vx1_reg, vy1_reg, ux1_reg, uy1_reg, dx1_reg, dy1_reg;
    logic signed [17:0] rw1_reg, ri1_reg;
    logic rect1_reg, box1_reg;

    function automatic logic span(input logic signed [15:0] p, e1, e2,
                                  input logic [7:0] w);
        logic signed [17:0] pw, e1w, e2w;
        begin
            pw  = 18'(p)  + 18'(signed'({1'b0, w}));
            e1w = 18'(e1) + 18'(signed'({1'b0, w}));
            e2w = 18'(e2) + 18'(signed'({1'b0, w}));
            span = (18'(e1) < pw && 18'(p) < e2w) || (18'(e2) < pw && 18'(p) < e1w);
        end
    endfunction

    function automatic logic near(input logic signed [15:0] a, b,
                                  input logic [7:0] w);
        logic signed [16:0] d;
        logic [16:0] m;
        begin
            d = 17'(a) - 17'(b);
            m = d[16] ? 17'(-d) : 17'(d);
            near = m < {9'd0, w};
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            k1_reg  <= s_command;
            w1_reg  <= 18'({1'b0, s_tolerance});
            vx1_reg <= 17'(s_point_x) - 17'(s_shape_ax);
            vy1_reg <= 17'(s_point_y) - 17'(s_shape_ay);
            ux1_reg <= 17'(s_point_x) - 17'(s_shape_bx);
            uy1_reg <= 17'(s_point_y) - 17'(s_shape_by);
            dx1_reg <= 17'(s_shape_bx) - 17'(s_shape_ax);
            dy1_reg <= 17'(s_shape_by) - 17'(s_shape_ay);
            rw1_reg <= 18'(s_shape_bx) + 18'({1'b0, s_tolerance});
            ri1_reg <= 18'(s_shape_bx) - 18'({1'b0, s_tolerance});
            rect1_reg <= ((near(s_shape_ax, s_point_x, s_tolerance) ||
                           near(s_shape_bx, s_point_x, s_tolerance)) &&
                          span(s_point_y, s_shape_ay, s_shape_by, s_tolerance)) ||
                         ((near(s_shape_ay, s_point_y, s_tolerance) ||
                           near(s_shape_by, s_point_y, s_tolerance)) &&
                          span(s_point_x, s_shape_ax, s_shape_bx, s_tolerance));
            box1_reg <= span(s_point_y, s_shape_ay, s_shape_by, s_tolerance) &&
                        span(s_point_x, s_shape_ax, s_shape_bx, s_tolerance);
        end
    end

    // ---------------- stage 2: products ----------------
    logic [1:0] k2_reg;
    logic [33:0] vxx2_reg, vyy2_reg, uxx2_reg, uyy2_reg, dxx2_reg, dyy2_reg;
    logic signed [34:0] tx2_reg, ty2_reg;
    logic [15:0] ww2_reg;
    logic [35:0] ro2_reg, rin2_reg;
    logic ropos2_reg, rinneg2_reg, misc2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            k2_reg   <= k1_reg;
            vxx2_reg <= 34'(vx1_reg * vx1_reg);
            vyy2_reg <= 34'(vy1_reg * vy1_reg);
            uxx2_reg <= 34'(ux1_reg * ux1_reg);
            uyy2_reg <= 34'(uy1_reg * uy1_reg);
            dxx2_reg <= 34'(dx1_reg * dx1_reg);
            dyy2_reg <= 34'(dy1_reg * dy1_reg);
            tx2_reg  <= 35'(vx1_reg * dx1_reg);
            ty2_reg  <= 35'(vy1_reg * dy1_reg);
            ww2_reg  <= 16'(w1_reg * w1_reg);
            ro2_reg  <= 36'(rw1_reg * rw1_reg);
            rin2_reg <= 36'(ri1_reg * ri1_reg);
            ropos2_reg  <= rw1_reg > 0;
            rinneg2_reg <= ri1_reg[17];
            misc2_reg <= (k1_reg == CMD_RECT) ? rect1_reg : box1_reg;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic [1:0] k3_reg;
    logic [35:0] vv3_reg, len3_reg;
    logic signed [36:0] t3_reg;
    logic end3_reg, circ3_reg, misc3_reg;
    logic [35:0] uu_s, vv_s, dd_s;
    assign vv_s = 36'(vxx2_reg) + 36'(vyy2_reg);
    assign uu_s = 36'(uxx2_reg) + 36'(uyy2_reg);
    assign dd_s = vv_s; // circle: v is point - centre
    always_ff @(posedge aclk) begin
        if (adv) begin
            k3_reg   <= k2_reg;
            vv3_reg  <= vv_s - 36'(ww2_reg);
            len3_reg <= 36'(dxx2_reg) + 36'(dyy2_reg);
            t3_reg   <= 37'(tx2_reg) + 37'(ty2_reg);
            end3_reg <= vv_s < 36'(ww2_reg) || uu_s < 36'(ww2_reg);
            circ3_reg <= ropos2_reg && dd_s < ro2_reg &&
                         (rinneg2_reg || dd_s > rin2_reg);
            misc3_reg <= misc2_reg;
        end
    end

    // ---------------- stage 4: split wide products ----------------
    // a = vv-ww (<2^34), b = len, c = t: compare a*len < t*t via 18-bit halves
    logic [1:0] k4_reg;
    logic gate4_reg, end4_reg, circ4_reg, misc4_reg;
    logic [35:0] t_abs;
    assign t_abs = t3_reg[36] ? 36'(-t3_reg) : 36'(t3_reg);
    logic [53:0] pl_ll_reg, pl_lh_reg, pl_hl_reg, pl_hh_reg;
    logic [53:0] pr_ll_reg, pr_lh_reg, pr_hl_reg, pr_hh_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            k4_reg   <= k3_reg;
            end4_reg <= end3_reg;
            circ4_reg <= circ3_reg;
            misc4_reg <= misc3_reg;
            gate4_reg <= !t3_reg[36] && $signed({1'b0, len3_reg}) >= t3_reg &&
                         len3_reg != '0;
            pl_ll_reg <= 54'(vv3_reg[17:0]  * len3_reg[17:0]);
            pl_lh_reg <= 54'(vv3_reg[17:0]  * len3_reg[35:18]);
            pl_hl_reg <= 54'(vv3_reg[35:18] * len3_reg[17:0]);
            pl_hh_reg <= 54'(vv3_reg[35:18] * len3_reg[35:18]);
            pr_ll_reg <= 54'(t_abs[17:0]  * t_abs[17:0]);
            pr_lh_reg <= 54'(t_abs[17:0]  * t_abs[35:18]);
            pr_hl_reg <= 54'(t_abs[35:18] * t_abs[17:0]);
            pr_hh_reg <= 54'(t_abs[35:18] * t_abs[35:18]);
        end
    end

    // ---------------- stage 5: final compare and select ----------------
    logic [71:0] lhs, rhs;
    logic hit_reg;
    assign lhs = 72'(pl_ll_reg) + (72'(pl_lh_reg) << 18) + (72'(pl_hl_reg) << 18)
               + (72'(pl_hh_reg) << 36);
    assign rhs = 72'(pr_ll_reg) + (72'(pr_lh_reg) << 18) + (72'(pr_hl_reg) << 18)
               + (72'(pr_hh_reg) << 36);
    always_ff @(posedge aclk) begin
        if (adv) begin
            unique case (k4_reg)
                CMD_LINE: hit_reg <= end4_reg || (gate4_reg && lhs < rhs);
                CMD_CIRC: hit_reg <= circ4_reg;
                default:  hit_reg <= misc4_reg;
            endcase
        end
    end
    assign m_hit = hit_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready mismatch");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("item lost at entry");
endmodule
`default_nettype wire

>>> sim/tb_shape_point_hit_test_core.sv
// ----------------------------------------------------------------------------
// Shape point hit test core testbench
// Drives queries for segments, outlines, circles and image boxes through the
// valid/ready input channel. Every accepted query is scored by a local exact
// integer predictor, and each hit flag that comes back is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_shape_point_hit_test_core
    import sph_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM  = 1800;
    localparam int PHASE_LEN   = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [7:0]         tol;
    } shape_query_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic signed [15:0] s_shape_ax = '0;
    logic signed [15:0] s_shape_ay = '0;
    logic signed [15:0] s_shape_bx = '0;
    logic signed [15:0] s_shape_by = '0;
    logic signed [15:0] s_point_x = '0;
    logic signed [15:0] s_point_y = '0;
    logic [7:0] s_tolerance = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;

    shape_query_t query_queue[$];
    logic         hit_queue[$];
    shape_query_t cur_query;
    int           sent_count = 0;
    int           recv_count = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    shape_point_hit_test_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command),
        .s_shape_ax(s_shape_ax), .s_shape_ay(s_shape_ay),
        .s_shape_bx(s_shape_bx), .s_shape_by(s_shape_by),
        .s_point_x(s_point_x), .s_point_y(s_point_y),
        .s_tolerance(s_tolerance),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit)
    );

    always #5 aclk = ~aclk;

    // Coordinate p lies within w of the span between e1 and e2 (either order).
    function automatic bit in_span(longint p, longint e1, longint e2, longint w);
        return (e1 < p + w && p < e2 + w) || (e2 < p + w && p < e1 + w);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Exact hit decision for one query.
    function automatic logic predict_hit(shape_query_t q);
        longint ax, ay, bx, by, px, py, w, ww;
        longint vx, vy, ux, uy, dx, dy, vv, t, len, dd, outer, inner;
        logic [127:0] lhs, rhs;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
        px = q.px; py = q.py; w = q.tol; ww = w * w;
        case (q.command)
            CMD_LINE: begin
                vx = px - ax; vy = py - ay;
                ux = px - bx; uy = py - by;
                dx = bx - ax; dy = by - ay;
                vv = vx * vx + vy * vy;
                // endpoint disks first
                if (vv < ww || ux * ux + uy * uy < ww)
                    return 1'b1;
                t = vx * dx + vy * dy;
                len = dx * dx + dy * dy;
                // off the segment or degenerate: endpoint test only
                if (t < 0 || t > len || len == 0)
                    return 1'b0;
                // perpendicular distance, squared and scaled by len, in 128 bits
                lhs = 128'(vv - ww) * 128'(len);
                rhs = 128'(t) * 128'(t);
                return lhs < rhs;
            end
            CMD_RECT: begin
                return ((mag(ax - px) < w || mag(bx - px) < w) && in_span(py, ay, by, w))
                    || ((mag(ay - py) < w || mag(by - py) < w) && in_span(px, ax, bx, w));
            end
            CMD_CIRC: begin
                dx = px - ax; dy = py - ay;
                dd = dx * dx + dy * dy;
                outer = bx + w; inner = bx - w;
                if (outer <= 0 || dd >= outer * outer)
                    return 1'b0;
                if (inner >= 0 && dd <= inner * inner)
                    return 1'b0;
                return 1'b1;
            end
            default: begin
                return in_span(py, ay, by, w) && in_span(px, ax, bx, w);
            end
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_full();
        return 16'($urandom);
    endfunction

    // Small coordinate around a random center so hits and near misses both show up.
    function automatic logic signed [15:0] rnd_near(int center, int spread);
        int v;
        v = center + $urandom_range(2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic add_query(logic [1:0] cmd, int ax, int ay, int bx, int by,
                             int px, int py, int tol);
        shape_query_t q;
        q.command = cmd;
        q.ax = 16'(ax); q.ay = 16'(ay); q.bx = 16'(bx); q.by = 16'(by);
        q.px = 16'(px); q.py = 16'(py); q.tol = 8'(tol);
        query_queue.push_back(q);
    endtask

    // Build one random query: mostly local geometry, some full-range noise.
    task automatic add_random_query();
        shape_query_t q;
        int cx, cy, sp;
        q.command = 2'($urandom);
        q.tol = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24));
        if ($urandom_range(7) == 0) begin
            q.ax = rnd_full(); q.ay = rnd_full(); q.bx = rnd_full(); q.by = rnd_full();
            q.px = rnd_full(); q.py = rnd_full();
            if ($urandom_range(1)) begin
                q.px = rnd_near(q.ax, 300); q.py = rnd_near(q.ay, 300);
            end
        end else begin
            cx = $signed(rnd_full()); cy = $signed(rnd_full());
            sp = ($urandom_range(3) == 0) ? 2000 : 80;
            q.ax = rnd_near(cx, sp); q.ay = rnd_near(cy, sp);
            q.bx = rnd_near(cx, sp); q.by = rnd_near(cy, sp);
            if (q.command == CMD_CIRC)
                q.bx = 16'($urandom_range(sp) - ($urandom_range(15) == 0 ? 20 : 0));
            q.px = rnd_near(cx, sp + 30); q.py = rnd_near(cy, sp + 30);
        end
        query_queue.push_back(q);
    endtask

    // Driver: score the item taken at this edge, then offer the next one.
    always @(posedge aclk) begin
        logic next_valid;
        int idle_pct;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hit_queue.push_back(predict_hit(cur_query));
                sent_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && query_queue.size() > 0) begin
                idle_pct = (sent_count < PHASE_LEN) ? 29 :
                           (sent_count < 2 * PHASE_LEN) ? 53 : 0;
                if ($urandom_range(99) >= idle_pct) begin
                    cur_query = query_queue.pop_front();
                    s_command <= cur_query.command;
                    s_shape_ax <= cur_query.ax;
                    s_shape_ay <= cur_query.ay;
                    s_shape_bx <= cur_query.bx;
                    s_shape_by <= cur_query.by;
                    s_point_x <= cur_query.px;
                    s_point_y <= cur_query.py;
                    s_tolerance <= cur_query.tol;
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Monitor: check the hit flag against the oldest prediction, then pick ready.
    always @(posedge aclk) begin
        logic exp_hit;
        int stall_pct;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                recv_count++;
                if (hit_queue.size() == 0) begin
                    mismatches++;
                    $error("result with nothing expected: hit=%0b", m_hit);
                end else begin
                    exp_hit = hit_queue.pop_front();
                    if (m_hit !== exp_hit) begin
                        mismatches++;
                        $error("field hit: expected %0b actual %0b", exp_hit, m_hit);
                    end
                end
            end
            // hold off once for a long stretch so the pipeline backs up
            if (!hold_done && recv_count >= 2 * PHASE_LEN + 50) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            stall_pct = (recv_count < PHASE_LEN) ? 53 :
                        (recv_count < 2 * PHASE_LEN) ? 29 : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // extremes and each shape kind
        add_query(CMD_LINE, -32768, -32768, 32767, 32767, 0, 0, 255);
        add_query(CMD_LINE, 0, 0, 100, 0, 50, 3, 4);       // perpendicular hit
        add_query(CMD_LINE, 0, 0, 100, 0, 50, 4, 4);       // on the band edge
        add_query(CMD_LINE, 0, 0, 100, 0, 103, 1, 4);      // near endpoint b
        add_query(CMD_LINE, 0, 0, 100, 0, 110, 0, 4);      // beyond the segment
        add_query(CMD_LINE, 7, 7, 7, 7, 8, 8, 2);          // degenerate segment
        add_query(CMD_LINE, 7, 7, 7, 7, 7, 7, 0);          // zero tolerance
        add_query(CMD_RECT, 10, 10, -10, -10, 10, 0, 1);   // corners swapped
        add_query(CMD_RECT, -10, -10, 10, 10, 0, 0, 5);    // interior miss
        add_query(CMD_RECT, -32768, -32768, 32767, 32767, 32767, 32767, 255);
        add_query(CMD_RECT, 0, 0, 5, 5, 0, 0, 0);
        add_query(CMD_CIRC, 0, 0, 50, 0, 30, 40, 1);       // on the circle
        add_query(CMD_CIRC, 0, 0, 50, 0, 0, 0, 10);        // centre, inside
        add_query(CMD_CIRC, 0, 0, -5, 0, 0, 0, 3);         // negative radius
        add_query(CMD_CIRC, 0, 0, 0, 0, 0, 0, 1);          // zero radius
        add_query(CMD_CIRC, -32768, 32767, 32767, -32768, 32767, -32768, 255);
        add_query(CMD_CIRC, 0, 0, 50, 0, 30, 40, 0);
        add_query(CMD_BOX, 5, 5, -5, -5, 0, 0, 0);         // strictly inside
        add_query(CMD_BOX, -5, -5, 5, 5, 5, 0, 0);         // on the edge
        add_query(CMD_BOX, -5, -5, 5, 5, 8, 0, 4);         // grown box
        add_query(CMD_BOX, 32767, 32767, -32768, -32768, -32768, 32767, 255);
        for (int i = 0; i < NUM_RANDOM; i++)
            add_random_query();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: all items sent, then every prediction answered
        while (query_queue.size() > 0 || s_valid || hit_queue.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
